[hw/rtl/nte_pkg.sv]
// ============================================================================
// N-tuple evaluator package
// Shared constants, types and a helper function for the n-tuple value
// evaluator: table geometry, request codes, sequencer controls and weight
// saturation.
// ============================================================================
package nte_pkg;

    localparam int FOUR_TUPLES = 12;
    localparam int WEIGHT_BITS = 32;

    localparam int BOARD_W  = 64;
    localparam int DELTA_W  = 32;
    localparam int IDX_W    = 20;
    localparam int WVAL_W   = 32;
    localparam int VALUE_W  = 36;
    localparam int RATE_W   = 16;
    localparam int SLOT_W   = 16;

    localparam int TABLE_DEPTH = FOUR_TUPLES * (1 << SLOT_W);
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int TUPLE_W     = (FOUR_TUPLES > 1) ? $clog2(FOUR_TUPLES) : 1;
    localparam int CNT_W       = $clog2(FOUR_TUPLES + 1);

    localparam int SUM_W  = VALUE_W + 1;
    localparam int PROD_W = DELTA_W + RATE_W + 1;
    localparam int RND_W  = PROD_W + 1;
    localparam int STEP_W = RND_W - 16;

    localparam logic [RATE_W-1:0] LEARN_RATE_RESET = 16'd655;

    typedef logic [1:0]              req_t;
    typedef logic [WEIGHT_BITS-1:0]  weight_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam req_t REQ_EVAL   = 2'd0;
    localparam req_t REQ_UPDATE = 2'd1;
    localparam req_t REQ_CLEAR  = 2'd2;
    localparam req_t REQ_WRITE  = 2'd3;

    typedef struct packed {
        logic mul_en;
        logic rnd_en;
        logic acc_clr;
        logic acc_en;
        logic update_mode;
    } alu_ctrl_t;

    localparam sum_t WMAX_EXT = SUM_W'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
    localparam sum_t WMIN_EXT = -WMAX_EXT - SUM_W'(1);

    function automatic weight_t sat_weight(input sum_t v);
        weight_t r;
        if (v > WMAX_EXT) begin
            r = WMAX_EXT[WEIGHT_BITS-1:0];
        end else if (v < WMIN_EXT) begin
            r = WMIN_EXT[WEIGHT_BITS-1:0];
        end else begin
            r = v[WEIGHT_BITS-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/n_tuple_value_evaluator.sv]
// ============================================================================
// N-tuple value evaluator
// Sums and trains the weights of a fixed n-tuple network over a 4x4 board.
// ============================================================================
// After reset the block sweeps the whole weight table to zero, one entry per
// cycle, before s_ready first rises. Every transaction returns exactly one
// result. An update first forms the weight step in S_MUL and S_RND; evaluate
// and update then read the tuple weights in S_RUN, one tuple weight per cycle
// from the single read port of the weight memory. Write requests and terminal
// boards go straight to S_DONE, and a clear request repeats the full table
// sweep. One transaction is in work at a time; a finished result may wait in
// the output register while the next transaction is accepted.
// ============================================================================
module n_tuple_value_evaluator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [nte_pkg::RATE_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  nte_pkg::req_t                       s_req_type,
    input  logic [nte_pkg::BOARD_W-1:0]         s_board,
    input  logic                                s_terminal,
    input  logic signed [nte_pkg::DELTA_W-1:0]  s_delta,
    input  logic [nte_pkg::IDX_W-1:0]           s_weight_index,
    input  logic signed [nte_pkg::WVAL_W-1:0]   s_weight_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [nte_pkg::VALUE_W-1:0]  m_value
);
    import nte_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_RND,
        S_RUN,
        S_DONE
    } state_t;

    localparam addr_t           LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W:0]  DEPTH_CMP = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(FOUR_TUPLES);

    state_t                     state_reg;
    logic [RATE_W-1:0]          learn_rate_reg;
    req_t                       req_reg;
    logic [BOARD_W-1:0]         board_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       pipe_reg;
    addr_t                      addr_d_reg;
    addr_t                      clr_addr_reg;
    logic                       m_valid_reg;
    logic signed [VALUE_W-1:0]  m_value_reg;

    logic                       accept;
    logic                       issue;
    logic                       out_load;
    logic                       wr_req_ok;
    addr_t                      tuple_addr;
    weight_t                    rdata;
    weight_t                    wnew;
    logic signed [VALUE_W-1:0]  acc;
    alu_ctrl_t                  alu_ctrl;
    logic                       ram_we;
    addr_t                      ram_waddr;
    weight_t                    ram_wdata;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign issue     = (state_reg == S_RUN) && (cnt_reg < CNT_END);
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign wr_req_ok = accept && (s_req_type == REQ_WRITE)
                       && ({1'b0, s_weight_index} < DEPTH_CMP);

    nte_addr u_addr (
        .board     (board_reg),
        .tuple_idx (cnt_reg[TUPLE_W-1:0]),
        .addr      (tuple_addr)
    );

    always_comb begin
        alu_ctrl.mul_en      = (state_reg == S_MUL);
        alu_ctrl.rnd_en      = (state_reg == S_RND);
        alu_ctrl.acc_clr     = accept;
        alu_ctrl.acc_en      = (state_reg == S_RUN) && pipe_reg && (req_reg == REQ_EVAL);
        alu_ctrl.update_mode = (req_reg == REQ_UPDATE);
    end

    nte_alu u_alu (
        .aclk       (aclk),
        .ctrl       (alu_ctrl),
        .delta      (delta_reg),
        .learn_rate (learn_rate_reg),
        .rdata      (rdata),
        .acc        (acc),
        .wnew       (wnew)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_d_reg;
        ram_wdata = wnew;
        if (state_reg == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (wr_req_ok) begin
            ram_we    = 1'b1;
            ram_waddr = s_weight_index[ADDR_W-1:0];
            ram_wdata = sat_weight(SUM_W'(s_weight_value));
        end else if ((state_reg == S_RUN) && pipe_reg && (req_reg == REQ_UPDATE)) begin
            ram_we    = 1'b1;
        end
    end

    nte_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (tuple_addr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            learn_rate_reg <= LEARN_RATE_RESET;
            req_reg        <= REQ_EVAL;
            cnt_reg        <= '0;
            pipe_reg       <= 1'b0;
            clr_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                learn_rate_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    if (clr_addr_reg == LAST_ADDR) begin
                        clr_addr_reg <= '0;
                        state_reg    <= (req_reg == REQ_CLEAR) ? S_DONE : S_IDLE;
                    end else begin
                        clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        req_reg   <= s_req_type;
                        board_reg <= s_board;
                        delta_reg <= s_delta;
                        cnt_reg   <= '0;
                        pipe_reg  <= 1'b0;
                        unique case (s_req_type)
                            REQ_EVAL:   state_reg <= s_terminal ? S_DONE : S_RUN;
                            REQ_UPDATE: state_reg <= s_terminal ? S_DONE : S_MUL;
                            REQ_CLEAR:  state_reg <= S_CLEAR;
                            REQ_WRITE:  state_reg <= S_DONE;
                            default:    state_reg <= S_DONE;
                        endcase
                    end
                end
                S_MUL: begin
                    state_reg <= S_RND;
                end
                S_RND: begin
                    state_reg <= S_RUN;
                end
                S_RUN: begin
                    pipe_reg   <= issue;
                    addr_d_reg <= tuple_addr;
                    if (issue) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end else if (!pipe_reg) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        m_valid_reg <= 1'b1;
                        m_value_reg <= acc;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    a_clear_writes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> (ram_we && (ram_wdata == '0)))
        else $error("clearing pass does not write zero");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_END)
        else $error("tuple counter ran past the tuple count");

    a_update_writes_back: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_RUN) && pipe_reg && (req_reg == REQ_UPDATE))
        |-> (ram_we && (ram_waddr == addr_d_reg)))
        else $error("update read was not written back");

    a_non_eval_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (req_reg != REQ_EVAL)) |=> (m_value_reg == '0))
        else $error("non-evaluate transaction returned a nonzero value");

    a_one_read_per_tuple: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_reg && (state_reg == S_RUN)) |-> $past(issue))
        else $error("weight consumed without a matching read");

endmodule

[hw/rtl/nte_addr.sv]
// ============================================================================
// N-tuple address generator
// Forms the weight table address of one tuple from the nibbles of the board
// cells that the tuple covers.
// ============================================================================
module nte_addr (
    input  logic [nte_pkg::BOARD_W-1:0] board,
    input  logic [nte_pkg::TUPLE_W-1:0] tuple_idx,
    output nte_pkg::addr_t              addr
);
    import nte_pkg::*;

    // Four cell numbers per tuple, first cell in the low nibble.
    function automatic logic [15:0] shape_row(input logic [3:0] t);
        logic [15:0] r;
        unique case (t)
            4'd0:    r = 16'h3210;
            4'd1:    r = 16'h7654;
            4'd2:    r = 16'hBA98;
            4'd3:    r = 16'hFEDC;
            4'd4:    r = 16'hC840;
            4'd5:    r = 16'hD951;
            4'd6:    r = 16'hEA62;
            4'd7:    r = 16'hFB73;
            4'd8:    r = 16'h5410;
            4'd9:    r = 16'h7632;
            4'd10:   r = 16'hDC98;
            4'd11:   r = 16'hFEBA;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    logic [15:0]                row;
    logic [SLOT_W-1:0]          slot;
    logic [TUPLE_W+SLOT_W-1:0]  addr_full;

    always_comb begin
        row = shape_row(4'(tuple_idx));
        for (int i = 0; i < 4; i++) begin
            slot[4*i +: 4] = board[{row[4*i +: 4], 2'b00} +: 4];
        end
        addr_full = {tuple_idx, slot};
    end

    assign addr = addr_full[ADDR_W-1:0];

endmodule

[hw/rtl/nte_ram.sv]
// ============================================================================
// Weight table memory
// Single write port and single read port with registered read data.
// ============================================================================
module nte_ram (
    input  logic             aclk,
    input  logic             we,
    input  nte_pkg::addr_t   waddr,
    input  nte_pkg::weight_t wdata,
    input  logic             re,
    input  nte_pkg::addr_t   raddr,
    output nte_pkg::weight_t rdata
);
    import nte_pkg::*;

    weight_t mem [TABLE_DEPTH];
    weight_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/nte_alu.sv]
// ============================================================================
// N-tuple arithmetic unit
// Forms the rounded weight step from delta and the learning rate, and holds
// the one adder shared by value accumulation and saturating weight updates.
// ============================================================================
module nte_alu (
    input  logic                                aclk,
    input  nte_pkg::alu_ctrl_t                  ctrl,
    input  logic signed [nte_pkg::DELTA_W-1:0]  delta,
    input  logic [nte_pkg::RATE_W-1:0]          learn_rate,
    input  nte_pkg::weight_t                    rdata,
    output logic signed [nte_pkg::VALUE_W-1:0]  acc,
    output nte_pkg::weight_t                    wnew
);
    import nte_pkg::*;

    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [STEP_W-1:0]  step_reg;
    logic signed [VALUE_W-1:0] acc_reg;
    logic signed [RND_W-1:0]   rnd;
    sum_t                      op_a;
    sum_t                      op_b;
    sum_t                      sum;

    assign rnd  = $signed({prod_reg[PROD_W-1], prod_reg}) + RND_W'(32768);
    assign op_a = ctrl.update_mode ? SUM_W'(step_reg) : SUM_W'(acc_reg);
    assign op_b = SUM_W'($signed(rdata));
    assign sum  = op_a + op_b;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= delta * $signed({1'b0, learn_rate});
        end
        if (ctrl.rnd_en) begin
            step_reg <= rnd[RND_W-1:16];
        end
        if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctrl.acc_en) begin
            acc_reg <= sum[VALUE_W-1:0];
        end
    end

    assign acc  = acc_reg;
    assign wnew = sat_weight(sum);

endmodule

[dv/n_tuple_value_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// N-tuple value evaluator checker
// Watches the request and result channels of the evaluator. It keeps a sparse
// copy of the weight table and the learning rate, works out the value that
// each accepted request should return, and compares every result against the
// oldest outstanding value.
// ============================================================================
module n_tuple_value_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [nte_pkg::RATE_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  nte_pkg::req_t                       s_req_type,
    input  logic [nte_pkg::BOARD_W-1:0]         s_board,
    input  logic                                s_terminal,
    input  logic signed [nte_pkg::DELTA_W-1:0]  s_delta,
    input  logic [nte_pkg::IDX_W-1:0]           s_weight_index,
    input  logic signed [nte_pkg::WVAL_W-1:0]   s_weight_value,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [nte_pkg::VALUE_W-1:0]  m_value,
    output int                                  fail_count,
    output int                                  pending
);
    import nte_pkg::*;

    // Cells of each tuple, one nibble per cell, tuple 0 in the low bits.
    localparam logic [12*16-1:0] TUPLE_CELLS = {
        16'hFEBA, 16'hDC98, 16'h7632, 16'h5410,
        16'hFB73, 16'hEA62, 16'hD951, 16'hC840,
        16'hFEDC, 16'hBA98, 16'h7654, 16'h3210
    };

    logic [RATE_W-1:0]  learn_rate;
    int                 weight_shadow [int];
    logic [VALUE_W-1:0] expected_values [int];
    int                 exp_head = 0;
    int                 exp_tail = 0;

    function automatic int tuple_addr(input logic [BOARD_W-1:0] brd, input int t);
        logic [15:0] cells;
        logic [15:0] key;
        cells = TUPLE_CELLS[16*t +: 16];
        for (int i = 0; i < 4; i++) begin
            key[4*i +: 4] = brd[4*cells[4*i +: 4] +: 4];
        end
        return t * 65536 + int'(key);
    endfunction

    function automatic longint read_weight(input int a);
        return weight_shadow.exists(a) ? longint'(weight_shadow[a]) : 64'sd0;
    endfunction

    function automatic int clamp_weight(input longint v);
        longint hi;
        hi = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
        if (v > hi) begin
            v = hi;
        end else if (v < -hi - 1) begin
            v = -hi - 1;
        end
        return int'(v);
    endfunction

    function automatic logic [VALUE_W-1:0] apply_request(
        input req_t                      rq,
        input logic [BOARD_W-1:0]        brd,
        input logic                      term,
        input logic signed [DELTA_W-1:0] dlt,
        input logic [IDX_W-1:0]          idx,
        input logic signed [WVAL_W-1:0]  wval
    );
        longint sum;
        longint step;
        int     a;
        sum = 0;
        case (rq)
            REQ_EVAL: begin
                if (!term) begin
                    for (int t = 0; t < FOUR_TUPLES; t++) begin
                        sum += read_weight(tuple_addr(brd, t));
                    end
                end
            end
            REQ_UPDATE: begin
                if (!term) begin
                    // Rounded to Q16.16 with halves going up.
                    step = (longint'(dlt) * longint'(learn_rate) + 64'sd32768) >>> 16;
                    for (int t = 0; t < FOUR_TUPLES; t++) begin
                        a = tuple_addr(brd, t);
                        weight_shadow[a] = clamp_weight(read_weight(a) + step);
                    end
                end
            end
            REQ_CLEAR: begin
                weight_shadow.delete();
            end
            default: begin
                if (idx < TABLE_DEPTH) begin
                    weight_shadow[int'(idx)] = clamp_weight(longint'(wval));
                end
            end
        endcase
        return sum[VALUE_W-1:0];
    endfunction

    always @(posedge aclk) begin : watch
        logic [VALUE_W-1:0] want;
        if (!aresetn) begin
            learn_rate = LEARN_RATE_RESET;
            weight_shadow.delete();
            expected_values.delete();
            exp_head = 0;
            exp_tail = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (exp_head == exp_tail) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("[%0t] result %0d arrived with no request outstanding",
                                 $realtime, m_value);
                    end
                end else begin
                    want = expected_values[exp_head];
                    expected_values.delete(exp_head);
                    exp_head++;
                    if (m_value !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("[%0t] value error: expected %0d, got %0d",
                                     $realtime, $signed(want), m_value);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_values[exp_tail] = apply_request(s_req_type, s_board, s_terminal,
                                                          s_delta, s_weight_index,
                                                          s_weight_value);
                exp_tail++;
            end
            if (cfg_we) begin
                learn_rate = cfg_wdata;
            end
        end
        pending = exp_tail - exp_head;
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// N-tuple value evaluator testbench
// Drives evaluate, update, clear and write transactions into the evaluator
// and lets the checker predict and compare each result. A short directed
// sequence covers the table edges, saturation, rounding and terminal boards;
// random traffic over a small pool of boards then trains and reads back the
// same weights under changing learning rates and back-pressure.
// ============================================================================
module tb;
    import nte_pkg::*;

    localparam longint CYCLE_LIMIT    = 64'd6_000_000;
    localparam int     RX_HOLD_CYCLES = 400;
    localparam int     POOL_SIZE      = 8;
    localparam logic [BOARD_W-1:0] BOARD_ZERO = '0;
    localparam logic [BOARD_W-1:0] BOARD_FULL = '1;

    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       cfg_we         = 1'b0;
    logic [RATE_W-1:0]          cfg_wdata      = '0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    req_t                       s_req_type     = REQ_EVAL;
    logic [BOARD_W-1:0]         s_board        = '0;
    logic                       s_terminal     = 1'b0;
    logic signed [DELTA_W-1:0]  s_delta        = '0;
    logic [IDX_W-1:0]           s_weight_index = '0;
    logic signed [WVAL_W-1:0]   s_weight_value = '0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic signed [VALUE_W-1:0]  m_value;

    int                 fail_count;
    int                 pending;
    int                 tx_idle_pct  = 0;
    int                 rx_idle_pct  = 0;
    bit                 hold_request = 1'b0;
    int                 hold_left    = 0;
    longint             cycle_count  = 0;
    logic [BOARD_W-1:0] board_pool [POOL_SIZE];

    n_tuple_value_evaluator i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_board        (s_board),
        .s_terminal     (s_terminal),
        .s_delta        (s_delta),
        .s_weight_index (s_weight_index),
        .s_weight_value (s_weight_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value)
    );

    n_tuple_value_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_board        (s_board),
        .s_terminal     (s_terminal),
        .s_delta        (s_delta),
        .s_weight_index (s_weight_index),
        .s_weight_value (s_weight_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The receiver stalls at random, or for a long stretch on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_request(
        input req_t                      rq,
        input logic [BOARD_W-1:0]        brd,
        input logic                      term,
        input logic signed [DELTA_W-1:0] dlt,
        input logic [IDX_W-1:0]          idx,
        input logic signed [WVAL_W-1:0]  wval
    );
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= rq;
        s_board        <= brd;
        s_terminal     <= term;
        s_delta        <= dlt;
        s_weight_index <= idx;
        s_weight_value <= wval;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_learn_rate(input logic [RATE_W-1:0] rate);
        wait_drained();
        repeat (20) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= rate;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_request();
        int                        pick;
        int                        t;
        req_t                      rq;
        logic [BOARD_W-1:0]        brd;
        logic                      term;
        logic signed [DELTA_W-1:0] dlt;
        logic [IDX_W-1:0]          idx;
        logic signed [WVAL_W-1:0]  wval;
        if ($urandom_range(0, 29) == 0) begin
            board_pool[$urandom_range(0, POOL_SIZE - 1)] = {$urandom, $urandom};
        end
        brd = board_pool[$urandom_range(0, POOL_SIZE - 1)];
        case ($urandom_range(0, 5))
            0: brd[4*$urandom_range(0, 15) +: 4] = 4'($urandom_range(0, 15));
            1: brd = {$urandom, $urandom};
            default: ;
        endcase
        term = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 9) < 7) begin
            dlt = $signed($urandom_range(0, 32'h0040_0000)) - 32'sd2097152;
        end else begin
            dlt = $urandom;
        end
        t = $urandom_range(0, 3);
        case ($urandom_range(0, 3))
            0, 1: idx = IDX_W'(t * 65536) | IDX_W'(brd[16*t +: 16]);
            2: idx = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
            default: idx = IDX_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: wval = 32'sh7FFF_FFFF;
            1: wval = 32'sh8000_0000;
            2: wval = $signed($urandom_range(0, 32'h0010_0000)) - 32'sd524288;
            default: wval = $urandom;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            rq = REQ_EVAL;
        end else if (pick < 80) begin
            rq = REQ_UPDATE;
        end else begin
            rq = REQ_WRITE;
        end
        send_request(rq, brd, term, dlt, idx, wval);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end

        send_request(REQ_EVAL,   BOARD_ZERO, 1'b0, '0, '0, '0);
        send_request(REQ_EVAL,   BOARD_FULL, 1'b0, '0, '0, '0);
        send_request(REQ_WRITE,  BOARD_ZERO, 1'b0, '0, 20'd0,      32'sh7FFF_FFFF);
        send_request(REQ_WRITE,  BOARD_ZERO, 1'b0, '0, 20'd65536,  32'sh8000_0000);
        send_request(REQ_WRITE,  BOARD_ZERO, 1'b0, '0, 20'd786431, 32'sh7FFF_FFFF);
        send_request(REQ_WRITE,  BOARD_ZERO, 1'b1, '0, 20'd786432, 32'sd1234);
        send_request(REQ_WRITE,  BOARD_ZERO, 1'b0, '0, 20'hFFFFF,  -32'sd1);
        send_request(REQ_EVAL,   BOARD_ZERO, 1'b0, '0, '0, '0);
        send_request(REQ_EVAL,   BOARD_FULL, 1'b0, '0, '0, '0);
        send_request(REQ_EVAL,   BOARD_ZERO, 1'b1, '0, '0, '0);
        send_request(REQ_UPDATE, BOARD_ZERO, 1'b0, 32'sh7FFF_FFFF, '0, '0);
        send_request(REQ_UPDATE, BOARD_FULL, 1'b1, 32'sh8000_0000, '0, '0);
        send_request(REQ_EVAL,   BOARD_FULL, 1'b0, '0, '0, '0);
        set_learn_rate(16'hFFFF);
        send_request(REQ_UPDATE, BOARD_FULL, 1'b0, 32'sh8000_0000, '0, '0);
        send_request(REQ_UPDATE, BOARD_FULL, 1'b0, 32'sh8000_0000, '0, '0);
        send_request(REQ_EVAL,   BOARD_FULL, 1'b0, '0, '0, '0);
        set_learn_rate(16'h8000);
        send_request(REQ_UPDATE, BOARD_ZERO, 1'b0, 32'sd1, '0, '0);
        send_request(REQ_UPDATE, BOARD_ZERO, 1'b0, -32'sd1, '0, '0);
        send_request(REQ_EVAL,   BOARD_ZERO, 1'b0, '0, '0, '0);
        set_learn_rate(16'h0000);
        send_request(REQ_UPDATE, BOARD_ZERO, 1'b0, 32'sh7FFF_FFFF, '0, '0);
        send_request(REQ_EVAL,   BOARD_ZERO, 1'b0, '0, '0, '0);
        send_request(REQ_CLEAR,  {$urandom, $urandom}, 1'b1, $urandom, '1, $urandom);
        send_request(REQ_EVAL,   BOARD_FULL, 1'b0, '0, '0, '0);
        send_request(REQ_EVAL,   BOARD_ZERO, 1'b0, '0, '0, '0);

        for (int p = 0; p < POOL_SIZE; p++) begin
            board_pool[p] = {$urandom, $urandom};
        end
        board_pool[0] = BOARD_ZERO;
        board_pool[1] = BOARD_FULL;

        for (int ph = 0; ph < 3; ph++) begin
            for (int half = 0; half < 2; half++) begin
                set_learn_rate((half == 1 && ph != 1) ? 16'hFFFF :
                               RATE_W'($urandom_range(0, 65535)));
                tx_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 82 : 0;
                rx_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 35 : 0;
                for (int n = 0; n < 125; n++) begin
                    if (n == 20 && half == 0 && ph != 1) begin
                        hold_request = 1'b1;
                    end
                    if ($urandom_range(0, 49) == 0) begin
                        wait_drained();
                    end
                    send_random_request();
                end
            end
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/nte_pkg.sv
hw/rtl/nte_addr.sv
hw/rtl/nte_ram.sv
hw/rtl/nte_alu.sv
hw/rtl/n_tuple_value_evaluator.sv
dv/n_tuple_value_checker.sv
dv/tb.sv
